[hw/rtl/rid_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rid_pkg
// Shared defaults for the recent identity duplicate filter and its entry RAM.
// ----------------------------------------------------------------------------
package rid_pkg;

  // Default geometry of the identity ring.
  localparam int DEF_DEPTH     = 16;
  localparam int DEF_KEY_BYTES = 8;
  localparam int DEF_HASH_BITS = 32;
  localparam int DEF_SEQ_BITS  = 32;

  // Fixed widths of the payload ports.
  localparam int KEY_PORT_W  = 64;
  localparam int HASH_PORT_W = 32;
  localparam int SEQ_PORT_W  = 32;
  localparam int DUP_W       = 32;
  localparam int HELD_W      = 5;

endpackage : rid_pkg
`default_nettype wire

[hw/rtl/recent_id_dedup_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// recent_id_dedup_table
// Duplicate filter over a ring of the most recent message identities
// (context key, content hash, sequence number), held in one entry RAM.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Beat contents
//  in       in_valid / in_ready    operation, context key, content hash, sequence
//  out      out_valid / out_ready  status, duplicates total, entries held
//
//  After acceptance an item is compared with every held entry by a scan that reads
//  one RAM entry per cycle; its result is then committed from the finish state.
//  A new item is accepted in the idle state, even while the previous result waits.
//  A stalled result holds the finished item before commit; the RAM is not touched.
//  Synchronous active-low reset clears the pointer, count and duplicate counter;
//  RAM contents are not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module recent_id_dedup_table #(
  parameter int DEPTH     = rid_pkg::DEF_DEPTH,
  parameter int KEY_BYTES = rid_pkg::DEF_KEY_BYTES,
  parameter int HASH_BITS = rid_pkg::DEF_HASH_BITS,
  parameter int SEQ_BITS  = rid_pkg::DEF_SEQ_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_operation,
  input  wire logic [rid_pkg::KEY_PORT_W-1:0]   in_context_key,
  input  wire logic [rid_pkg::HASH_PORT_W-1:0]  in_content_hash,
  input  wire logic [rid_pkg::SEQ_PORT_W-1:0]   in_sequence_number,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_status,
  output logic [rid_pkg::DUP_W-1:0]             out_duplicates_total,
  output logic [rid_pkg::HELD_W-1:0]            out_entries_held
);

  localparam int KW = 8 * KEY_BYTES;
  localparam int HW = (HASH_BITS < rid_pkg::HASH_PORT_W) ? HASH_BITS : rid_pkg::HASH_PORT_W;
  localparam int SW = (SEQ_BITS < rid_pkg::SEQ_PORT_W) ? SEQ_BITS : rid_pkg::SEQ_PORT_W;
  localparam int EW = KW + HW + SW;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [EW-1:0]        item_r, item_nxt;
  logic                 op_r, op_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 hit_r, hit_nxt;
  logic                 rvalid_r, rvalid_nxt;
  logic [PW-1:0]        wp_r, wp_nxt;
  logic [CW-1:0]        held_r, held_nxt;
  logic [rid_pkg::DUP_W-1:0] dup_r, dup_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 status_r, status_nxt;

  logic                 issue;
  logic                 rd_en;
  logic [EW-1:0]        rd_data;
  logic                 match;
  logic                 commit;
  logic                 wr_en;
  logic [31:0]          held_wide;

  assign issue  = (idx_r < held_r);
  assign rd_en  = (state_r == ST_SCAN) && issue;
  assign match  = rvalid_r && (rd_data == item_r);
  assign commit = (state_r == ST_FINISH) && (!out_valid_r || out_ready);
  assign wr_en  = commit && op_r && !hit_r;

  rid_ram #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (item_r),
    .rd_en   (rd_en),
    .rd_addr (idx_r[PW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    rvalid_nxt    = rd_en;
    wp_nxt        = wp_r;
    held_nxt      = held_r;
    dup_nxt       = dup_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = {in_context_key[KW-1:0], in_content_hash[HW-1:0],
                       in_sequence_number[SW-1:0]};
          op_nxt    = in_operation;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          hit_nxt = 1'b1;
        end
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end else if (!rvalid_r) begin
          // Last read has been compared; the scan is complete.
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          status_nxt    = hit_r;
          state_nxt     = ST_IDLE;
          if (op_r) begin
            if (hit_r) begin
              dup_nxt = dup_r + 1'b1;
            end else begin
              wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
              if (held_r < CW'(DEPTH)) begin
                held_nxt = held_r + 1'b1;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rvalid_r    <= 1'b0;
      wp_r        <= '0;
      held_r      <= '0;
      dup_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rvalid_r    <= rvalid_nxt;
      wp_r        <= wp_nxt;
      held_r      <= held_nxt;
      dup_r       <= dup_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
  end

  // The counters only move at commit, so they are stable while a beat waits.
  assign held_wide            = 32'(held_r);
  assign in_ready             = (state_r == ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_duplicates_total = dup_r;
  assign out_entries_held     = held_wide[rid_pkg::HELD_W-1:0];

  // Until the ring fills, the write pointer equals the number of held entries.
  a_wp_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r < CW'(DEPTH)) |-> (CW'(wp_r) == held_r))
    else $error("write pointer out of step with held count");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(DEPTH))
    else $error("held count exceeds depth");

  // Read data is only taken from reads issued during the scan.
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rvalid_r |-> (state_r == ST_SCAN))
    else $error("RAM read data outside the scan");

  // The duplicate counter, held count and write pointer change only at commit.
  a_state_only_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> ($stable(dup_r) && $stable(held_r) && $stable(wp_r)))
    else $error("ring state changed without a commit");

  // The RAM is never written while the scan is reading it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("RAM write overlaps the scan");

endmodule : recent_id_dedup_table
`default_nettype wire

[hw/rtl/rid_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rid_ram
// Simple dual-port entry RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rid_ram #(
  parameter int DEPTH = rid_pkg::DEF_DEPTH,
  parameter int WIDTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : rid_ram
`default_nettype wire

[bench/identity_filter_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// identity_filter_checker
// Watches both channels of the duplicate filter, predicts each result beat
// from its own copy of the identity ring and compares it field by field.
// ----------------------------------------------------------------------------
package dedup_tb_pkg;

  typedef enum logic {
    OP_CHECK  = 1'b0,
    OP_RECORD = 1'b1
  } dedup_op_t;

  typedef struct packed {
    logic                       status;
    logic [rid_pkg::DUP_W-1:0]  dup_total;
    logic [rid_pkg::HELD_W-1:0] held;
  } verdict_t;

endpackage : dedup_tb_pkg

module identity_filter_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_operation,
  input  logic [rid_pkg::KEY_PORT_W-1:0]  in_context_key,
  input  logic [rid_pkg::HASH_PORT_W-1:0] in_content_hash,
  input  logic [rid_pkg::SEQ_PORT_W-1:0]  in_sequence_number,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_status,
  input  logic [rid_pkg::DUP_W-1:0]       out_duplicates_total,
  input  logic [rid_pkg::HELD_W-1:0]      out_entries_held,
  output int                              fail_count,
  output int                              pending
);

  localparam int RING = rid_pkg::DEF_DEPTH;
  localparam logic [63:0] KEY_MASK = (rid_pkg::DEF_KEY_BYTES >= 8) ? '1 :
      ((64'd1 << (8 * rid_pkg::DEF_KEY_BYTES)) - 64'd1);
  localparam logic [31:0] HASH_MASK = (rid_pkg::DEF_HASH_BITS >= 32) ? '1 :
      ((32'd1 << rid_pkg::DEF_HASH_BITS) - 32'd1);
  localparam logic [31:0] SEQ_MASK = (rid_pkg::DEF_SEQ_BITS >= 32) ? '1 :
      ((32'd1 << rid_pkg::DEF_SEQ_BITS) - 32'd1);

  logic [63:0] ring_key [RING];
  logic [31:0] ring_hash [RING];
  logic [31:0] ring_seq [RING];
  int          write_slot;
  int          held;
  logic [31:0] dup_count;
  dedup_tb_pkg::verdict_t expected_verdicts [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic dedup_tb_pkg::verdict_t lookup_and_record(
      dedup_tb_pkg::dedup_op_t op, logic [63:0] key, logic [31:0] hash,
      logic [31:0] seq);
    logic [63:0] k;
    logic [31:0] h;
    logic [31:0] s;
    logic        present;
    dedup_tb_pkg::verdict_t v;
    k = key & KEY_MASK;
    h = hash & HASH_MASK;
    s = seq & SEQ_MASK;
    present = 1'b0;
    // Only slots below the held count have ever been written.
    for (int i = 0; i < held; i++) begin
      if (ring_key[i] == k && ring_hash[i] == h && ring_seq[i] == s) present = 1'b1;
    end
    if (op == dedup_tb_pkg::OP_RECORD) begin
      if (present) begin
        dup_count = dup_count + 32'd1;
      end else begin
        ring_key[write_slot]  = k;
        ring_hash[write_slot] = h;
        ring_seq[write_slot]  = s;
        write_slot = (write_slot + 1) % RING;
        if (held < RING) held = held + 1;
      end
    end
    v.status    = present;
    v.dup_total = dup_count;
    v.held      = held[rid_pkg::HELD_W-1:0];
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    dedup_tb_pkg::verdict_t want;
    if (!rst_n) begin
      write_slot = 0;
      held       = 0;
      dup_count  = '0;
      expected_verdicts.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result beat with none expected",
                          64'(out_duplicates_total), 64'd0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", 64'(out_status), 64'(want.status));
          if (out_duplicates_total !== want.dup_total)
            report_mismatch("duplicates_total", 64'(out_duplicates_total),
                            64'(want.dup_total));
          if (out_entries_held !== want.held)
            report_mismatch("entries_held", 64'(out_entries_held), 64'(want.held));
        end
      end
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(lookup_and_record(
            dedup_tb_pkg::dedup_op_t'(in_operation),
            in_context_key, in_content_hash, in_sequence_number));
      end
    end
    pending = expected_verdicts.size();
  end

endmodule : identity_filter_checker

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives identities into the duplicate filter, first a directed sequence that
// covers empty, duplicate, near-miss and ring wrap cases, then random traffic
// drawn mostly from a pool of recent identities. Results are checked by the
// identity filter checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_ITEMS = 600;
  localparam int POOL_SIZE    = 24;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = rid_pkg::DEF_DEPTH + 8;
  localparam int HOLD_OFF     = 300;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_operation = 1'b0;
  logic [rid_pkg::KEY_PORT_W-1:0]  in_context_key = '0;
  logic [rid_pkg::HASH_PORT_W-1:0] in_content_hash = '0;
  logic [rid_pkg::SEQ_PORT_W-1:0]  in_sequence_number = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_status;
  logic [rid_pkg::DUP_W-1:0]       out_duplicates_total;
  logic [rid_pkg::HELD_W-1:0]      out_entries_held;
  int                              fail_count;
  int                              pending;
  int                              idle_cycles = 0;
  bit                              burst = 1'b0;

  logic [63:0] pool_key [POOL_SIZE];
  logic [31:0] pool_hash [POOL_SIZE];
  logic [31:0] pool_seq [POOL_SIZE];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  recent_id_dedup_table u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_context_key       (in_context_key),
    .in_content_hash      (in_content_hash),
    .in_sequence_number   (in_sequence_number),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_duplicates_total (out_duplicates_total),
    .out_entries_held     (out_entries_held)
  );

  identity_filter_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_context_key       (in_context_key),
    .in_content_hash      (in_content_hash),
    .in_sequence_number   (in_sequence_number),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_duplicates_total (out_duplicates_total),
    .out_entries_held     (out_entries_held),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_identity(input dedup_tb_pkg::dedup_op_t op,
                               input logic [63:0] key,
                               input logic [31:0] hash, input logic [31:0] seq);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= op;
    in_context_key     <= key;
    in_content_hash    <= hash;
    in_sequence_number <= seq;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [63:0] fresh_key();
    logic [63:0] key;
    int          bytes;
    key = {$urandom(), $urandom()};
    // Short context strings leave the upper bytes zero padded.
    if ($urandom_range(0, 2) == 0) begin
      bytes = $urandom_range(1, 7);
      key = key & ((64'd1 << (8 * bytes)) - 64'd1);
    end
    return key;
  endfunction

  // Result side: a random wait before each beat, calm stretches, and one long
  // hold-off so that the block backs up and drops in_ready.
  initial begin
    int  wait_cycles;
    int  taken;
    bit  steady;
    taken  = 0;
    steady = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 40 == 0) steady = ($urandom_range(0, 2) == 0);
      wait_cycles = steady ? 0 : $urandom_range(0, 5);
      if (taken == 150) wait_cycles = HOLD_OFF;
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    dedup_tb_pkg::dedup_op_t op;
    logic [63:0] key;
    logic [31:0] hash;
    logic [31:0] seq;
    int          pick;
    int          roll;
    int          flip;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty ring, duplicates, single-bit near misses, full ring.
    send_identity(dedup_tb_pkg::OP_CHECK,  64'h0, 32'h0, 32'h0);
    send_identity(dedup_tb_pkg::OP_RECORD, 64'h0, 32'h0, 32'h0);
    send_identity(dedup_tb_pkg::OP_RECORD, 64'h0, 32'h0, 32'h0);
    send_identity(dedup_tb_pkg::OP_CHECK,  64'h0, 32'h0, 32'h0);
    send_identity(dedup_tb_pkg::OP_RECORD, '1, '1, '1);
    send_identity(dedup_tb_pkg::OP_CHECK,  '1, '1, '1);
    send_identity(dedup_tb_pkg::OP_CHECK,  64'h7fff_ffff_ffff_ffff, '1, '1);
    send_identity(dedup_tb_pkg::OP_CHECK,  '1, 32'hffff_fffe, '1);
    send_identity(dedup_tb_pkg::OP_CHECK,  '1, '1, 32'h7fff_ffff);
    send_identity(dedup_tb_pkg::OP_RECORD, '1, '1, '1);
    send_identity(dedup_tb_pkg::OP_RECORD, 64'h8000_0000_0000_0000, 32'h0, 32'h0);
    send_identity(dedup_tb_pkg::OP_RECORD, 64'h5555_5555_5555_5555,
                  32'haaaa_aaaa, 32'h5555_5555);
    // Fill the ring, then one more record overwrites the all-zero identity.
    for (int i = 0; i < 13; i++) begin
      send_identity(dedup_tb_pkg::OP_RECORD, 64'h00aa_0000 + i, 32'h1000 + i, i);
    end
    send_identity(dedup_tb_pkg::OP_CHECK,  64'h0, 32'h0, 32'h0);

    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_key[i]  = fresh_key();
      pool_hash[i] = $urandom();
      pool_seq[i]  = $urandom();
    end

    // Random part: mostly repeats of recent identities so records hit duplicates,
    // some one-bit variants, and fresh identities that push old ones out.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      op   = dedup_tb_pkg::dedup_op_t'($urandom_range(0, 1));
      pick = $urandom_range(0, POOL_SIZE - 1);
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        key  = pool_key[pick];
        hash = pool_hash[pick];
        seq  = pool_seq[pick];
        if (roll >= 55) begin
          flip = $urandom_range(0, 2);
          case (flip)
            0: key[$urandom_range(0, 63)] ^= 1'b1;
            1: hash[$urandom_range(0, 31)] ^= 1'b1;
            default: seq[$urandom_range(0, 31)] ^= 1'b1;
          endcase
        end
      end else begin
        key  = fresh_key();
        hash = $urandom();
        seq  = $urandom();
        pool_key[pick]  = key;
        pool_hash[pick] = hash;
        pool_seq[pick]  = seq;
      end
      send_identity(op, key, hash, seq);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule : tb_top
